### sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and constants of the i2c register access master
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  localparam int unsigned PHASE_WIDTH       = 16;
  localparam int unsigned CFG_WIDTH         = 16;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd50;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [3:0] {
    SEQ_IDLE     = 4'd0,
    SEQ_START    = 4'd1,
    SEQ_SLAVE    = 4'd2,
    SEQ_REG      = 4'd3,
    SEQ_DATA     = 4'd4,
    SEQ_RESTART  = 4'd5,
    SEQ_SLAVE_RD = 4'd6,
    SEQ_READ     = 4'd7,
    SEQ_STOP     = 4'd8
  } seq_e;

  // one tick of bus activity as seen by the back end
  typedef struct packed {
    logic       start_req;
    logic       cmd;
    logic [7:0] slave_byte;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       error;
    logic [7:0] read_data;
  } res_t;

  // queue side of the front to back link
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

`default_nettype wire

### sv/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// input side: takes tick transfers and holds them in a short queue
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_front #(
  parameter int unsigned QueueDepth = i2cm_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire i2cm_pkg::item_t in_item_i,
  output i2cm_pkg::q_head_t    head_o,
  input  wire logic            pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  i2cm_pkg::item_t mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;

  assign in_ready_o = (cnt_q < CntW'(QueueDepth));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

`default_nettype wire

### sv/i2cm_back.sv
// ----------------------------------------------------------------------------
// i2cm_back
// bus sequencer: phase timer, byte shifter and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_back #(
  parameter int unsigned PhaseWidth = i2cm_pkg::PHASE_WIDTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [i2cm_pkg::CFG_WIDTH-1:0]    phase_ticks_i,
  input  wire i2cm_pkg::q_head_t                 head_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output i2cm_pkg::res_t                         res_o
);

  localparam int unsigned LimW =
    (PhaseWidth > i2cm_pkg::CFG_WIDTH) ? PhaseWidth : i2cm_pkg::CFG_WIDTH;

  i2cm_pkg::seq_e        step_q, step_d;
  logic [1:0]            sub_q, sub_d;
  logic [PhaseWidth-1:0] cnt_q, cnt_d, cnt_inc;
  logic [3:0]            bit_q, bit_d;
  logic [7:0]            shift_q, shift_d, shift_v;
  logic                  cmd_q, cmd_d;
  logic [7:0]            slave_q, slave_d;
  logic [7:0]            reg_q, reg_d;
  logic [7:0]            data_q, data_d;
  logic                  err_q, err_d;
  logic [7:0]            rdata_q, rdata_d;
  logic                  ack_q, ack_d, ack_v;
  logic                  done_d;
  logic                  phase_end;
  logic [LimW-1:0]       lim;
  logic [LimW-1:0]       cfg_ext;
  logic [LimW-1:0]       mask_ext;
  logic                  scl_d, sdo_d;
  logic                  out_valid_q;
  i2cm_pkg::res_t        res_q;
  i2cm_pkg::item_t       it;

  assign it          = head_i.item;
  assign pop_o       = head_i.valid && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // phase length: zero acts as one, saturated to the counter range
  assign cfg_ext  = LimW'(phase_ticks_i);
  assign mask_ext = LimW'({PhaseWidth{1'b1}});
  always_comb begin
    lim = cfg_ext;
    if (lim == '0) begin
      lim = LimW'(1);
    end
    if (lim > mask_ext) begin
      lim = mask_ext;
    end
  end

  // next state
  always_comb begin
    step_d    = step_q;
    sub_d     = sub_q;
    cnt_d     = cnt_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    cmd_d     = cmd_q;
    slave_d   = slave_q;
    reg_d     = reg_q;
    data_d    = data_q;
    err_d     = err_q;
    rdata_d   = rdata_q;
    ack_d     = ack_q;
    done_d    = 1'b0;
    phase_end = 1'b0;
    shift_v   = shift_q;
    ack_v     = ack_q;
    cnt_inc   = cnt_q + 1'b1;

    if (step_q == i2cm_pkg::SEQ_IDLE) begin
      if (it.start_req) begin
        cmd_d   = it.cmd;
        slave_d = it.slave_byte;
        reg_d   = it.reg_addr;
        data_d  = it.write_data;
        step_d  = i2cm_pkg::SEQ_START;
        sub_d   = '0;
        cnt_d   = '0;
        bit_d   = '0;
        shift_d = '0;
        ack_d   = 1'b0;
        err_d   = 1'b1;
      end
    end else if (LimW'(cnt_inc) >= lim) begin
      cnt_d     = '0;
      phase_end = 1'b1;
    end else begin
      cnt_d = cnt_inc;
    end

    if (phase_end) begin
      unique case (step_q)
        i2cm_pkg::SEQ_START, i2cm_pkg::SEQ_RESTART: begin
          if (sub_q < 2'd2) begin
            sub_d = sub_q + 1'b1;
          end else begin
            sub_d = '0;
            bit_d = '0;
            ack_d = 1'b0;
            if (step_q == i2cm_pkg::SEQ_START) begin
              shift_d = slave_q;
              step_d  = i2cm_pkg::SEQ_SLAVE;
            end else begin
              shift_d = slave_q + 8'd1;
              step_d  = i2cm_pkg::SEQ_SLAVE_RD;
            end
          end
        end
        i2cm_pkg::SEQ_SLAVE, i2cm_pkg::SEQ_REG, i2cm_pkg::SEQ_DATA,
        i2cm_pkg::SEQ_SLAVE_RD, i2cm_pkg::SEQ_READ: begin
          if (sub_q == 2'd1) begin
            if (step_q == i2cm_pkg::SEQ_READ) begin
              if (bit_q < 4'd8) begin
                shift_v = {shift_q[6:0], it.sda_in};
              end
            end else if (bit_q == 4'd8) begin
              ack_v = it.sda_in;
            end
          end
          ack_d   = ack_v;
          shift_d = shift_v;
          if (sub_q < 2'd2) begin
            sub_d = sub_q + 1'b1;
          end else begin
            sub_d = '0;
            if (bit_q < 4'd8) begin
              if (step_q != i2cm_pkg::SEQ_READ) begin
                shift_d = {shift_v[6:0], 1'b0};
              end
              bit_d = bit_q + 1'b1;
            end else begin
              bit_d = '0;
              if (step_q != i2cm_pkg::SEQ_READ && ack_v) begin
                step_d = i2cm_pkg::SEQ_STOP;
              end else begin
                unique case (step_q)
                  i2cm_pkg::SEQ_SLAVE: begin
                    step_d  = i2cm_pkg::SEQ_REG;
                    shift_d = reg_q;
                  end
                  i2cm_pkg::SEQ_REG: begin
                    if (cmd_q == i2cm_pkg::CMD_READ) begin
                      step_d = i2cm_pkg::SEQ_RESTART;
                    end else begin
                      step_d  = i2cm_pkg::SEQ_DATA;
                      shift_d = data_q;
                    end
                  end
                  i2cm_pkg::SEQ_SLAVE_RD: begin
                    step_d  = i2cm_pkg::SEQ_READ;
                    shift_d = '0;
                  end
                  default: begin
                    err_d  = 1'b0;
                    step_d = i2cm_pkg::SEQ_STOP;
                  end
                endcase
              end
            end
          end
        end
        i2cm_pkg::SEQ_STOP: begin
          if (sub_q < 2'd3) begin
            sub_d = sub_q + 1'b1;
          end else begin
            done_d = 1'b1;
            if (cmd_q == i2cm_pkg::CMD_READ) begin
              rdata_d = err_q ? 8'd0 : shift_q;
            end
            step_d = i2cm_pkg::SEQ_IDLE;
            sub_d  = '0;
          end
        end
        default: begin
          step_d = i2cm_pkg::SEQ_IDLE;
          sub_d  = '0;
        end
      endcase
    end
  end

  // bus levels after this tick
  always_comb begin
    scl_d = 1'b1;
    sdo_d = 1'b1;
    unique case (step_d)
      i2cm_pkg::SEQ_START, i2cm_pkg::SEQ_RESTART: begin
        scl_d = (sub_d < 2'd2);
        sdo_d = (sub_d == 2'd0);
      end
      i2cm_pkg::SEQ_SLAVE, i2cm_pkg::SEQ_REG, i2cm_pkg::SEQ_DATA,
      i2cm_pkg::SEQ_SLAVE_RD, i2cm_pkg::SEQ_READ: begin
        scl_d = (sub_d == 2'd1);
        sdo_d = (step_d == i2cm_pkg::SEQ_READ || bit_d >= 4'd8) ? 1'b1 : shift_d[7];
      end
      i2cm_pkg::SEQ_STOP: begin
        scl_d = (sub_d >= 2'd2);
        sdo_d = (sub_d == 2'd0 || sub_d == 2'd3);
      end
      default: begin
        scl_d = 1'b1;
        sdo_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= i2cm_pkg::SEQ_IDLE;
      sub_q       <= '0;
      cnt_q       <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      cmd_q       <= 1'b0;
      slave_q     <= '0;
      reg_q       <= '0;
      data_q      <= '0;
      err_q       <= 1'b0;
      rdata_q     <= '0;
      ack_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        step_q  <= step_d;
        sub_q   <= sub_d;
        cnt_q   <= cnt_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        cmd_q   <= cmd_d;
        slave_q <= slave_d;
        reg_q   <= reg_d;
        data_q  <= data_d;
        err_q   <= err_d;
        rdata_q <= rdata_d;
        ack_q   <= ack_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q.scl_out   <= scl_d;
      res_q.sda_out   <= sdo_d;
      res_q.busy_res  <= (step_d != i2cm_pkg::SEQ_IDLE);
      res_q.done_res  <= done_d;
      res_q.error     <= err_d;
      res_q.read_data <= rdata_d;
    end
  end

endmodule

`default_nettype wire

### sv/i2c_register_access_master.sv
// ----------------------------------------------------------------------------
// i2c_register_access_master
// bit-level i2c master for single register writes and reads
//
// channel  direction  transfer   payload
// in       input      one tick   start_req, cmd, slave_byte, reg_addr,
//                                write_data, sda_in
// out      output     one tick   scl_out, sda_out, busy_res, done_res,
//                                error, read_data
// cfg      input      write      phase_ticks (no handshake)
//
// one tick transfer per cycle sustained while the out channel is not stalled;
// a tick waits in the queue, is written to the result register when the
// sequencer pops it, and its result is then offered on the out channel
// the queue holds QueueDepth ticks, so input and output stall independently
// reset clears the sequencer to idle and phase_ticks to 50
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_register_access_master #(
  parameter int unsigned PhaseWidth = i2cm_pkg::PHASE_WIDTH,
  parameter int unsigned QueueDepth = i2cm_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [i2cm_pkg::CFG_WIDTH-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           start_req_i,
  input  wire logic                           cmd_i,
  input  wire logic [7:0]                     slave_byte_i,
  input  wire logic [7:0]                     reg_addr_i,
  input  wire logic [7:0]                     write_data_i,
  input  wire logic                           sda_in_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                scl_out_o,
  output logic                                sda_out_o,
  output logic                                busy_res_o,
  output logic                                done_res_o,
  output logic                                error_o,
  output logic [7:0]                          read_data_o
);

  logic [i2cm_pkg::CFG_WIDTH-1:0] phase_ticks_q;
  i2cm_pkg::item_t                in_item;
  i2cm_pkg::q_head_t              head;
  i2cm_pkg::res_t                 res;
  logic                           pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= i2cm_pkg::PHASE_TICKS_RESET;
    end else if (cfg_we_i) begin
      phase_ticks_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    in_item.start_req  = start_req_i;
    in_item.cmd        = cmd_i;
    in_item.slave_byte = slave_byte_i;
    in_item.reg_addr   = reg_addr_i;
    in_item.write_data = write_data_i;
    in_item.sda_in     = sda_in_i;
  end

  i2cm_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .head_o     (head),
    .pop_i      (pop)
  );

  i2cm_back #(
    .PhaseWidth (PhaseWidth)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .phase_ticks_i (phase_ticks_q),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .res_o         (res)
  );

  assign scl_out_o   = res.scl_out;
  assign sda_out_o   = res.sda_out;
  assign busy_res_o  = res.busy_res;
  assign done_res_o  = res.done_res;
  assign error_o     = res.error;
  assign read_data_o = res.read_data;

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the i2c register access master tick by tick against its own model
//
// a queue of bus ticks is built phase by phase, each phase opened with a new
// phase_ticks value once the block has gone quiet; a clocked driver feeds the
// ticks with random gaps and stalls the result side at random, a clocked
// monitor predicts the pin levels and flags of every accepted tick and
// compares each result field by field with the oldest prediction
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned N_PHASES    = 9;

  typedef struct packed {
    logic [15:0]                      ticks;
    logic [i2cm_pkg::PHASE_WIDTH-1:0] count;
    i2cm_pkg::seq_e                   seq;
    logic [1:0]                       sub;
    logic [3:0]                       bitn;
    logic [7:0]                       shreg;
    logic                             cmd;
    logic [7:0]                       slave;
    logic [7:0]                       regb;
    logic [7:0]                       data;
    logic                             err;
    logic                             ackf;
    logic [7:0]                       rdata;
  } bus_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [i2cm_pkg::CFG_WIDTH-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  i2cm_pkg::item_t cur_tick = '0;

  logic in_ready_o, out_valid_o;
  logic scl_out_o, sda_out_o, busy_res_o, done_res_o, error_o;
  logic [7:0] read_data_o;

  i2cm_pkg::item_t tick_q[$];
  i2cm_pkg::res_t bus_levels_q[$];
  bus_state_t seq_model;
  bus_state_t seq_ahead;

  logic in_taken = 1'b0;
  logic calm = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned n_mismatch = 0;
  int unsigned n_results = 0;
  int unsigned cycles = 0;

  i2c_register_access_master dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .start_req_i (cur_tick.start_req),
    .cmd_i       (cur_tick.cmd),
    .slave_byte_i(cur_tick.slave_byte),
    .reg_addr_i  (cur_tick.reg_addr),
    .write_data_i(cur_tick.write_data),
    .sda_in_i    (cur_tick.sda_in),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .scl_out_o   (scl_out_o),
    .sda_out_o   (sda_out_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .error_o     (error_o),
    .read_data_o (read_data_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic bus_state_t bus_reset();
    bus_state_t s;
    s = '0;
    s.ticks = i2cm_pkg::PHASE_TICKS_RESET;
    s.seq = i2cm_pkg::SEQ_IDLE;
    return s;
  endfunction

  // advances the sequencer by one tick and returns the levels it then shows
  function automatic i2cm_pkg::res_t next_bus_levels(inout bus_state_t s,
                                                     input i2cm_pkg::item_t it);
    i2cm_pkg::res_t r;
    longint unsigned cap;
    longint unsigned lim;
    logic done;
    cap = (64'd1 << i2cm_pkg::PHASE_WIDTH) - 64'd1;
    lim = (s.ticks == '0) ? 64'd1 : 64'(s.ticks);
    if (lim > cap) lim = cap;
    done = 1'b0;
    if (s.seq == i2cm_pkg::SEQ_IDLE) begin
      if (it.start_req) begin
        s.cmd = it.cmd;
        s.slave = it.slave_byte;
        s.regb = it.reg_addr;
        s.data = it.write_data;
        s.seq = i2cm_pkg::SEQ_START;
        s.sub = '0;
        s.count = '0;
        s.bitn = '0;
        s.shreg = '0;
        s.ackf = 1'b0;
        s.err = 1'b1;
      end
    end else begin
      s.count = s.count + 1'b1;
      if (64'(s.count) >= lim) begin
        s.count = '0;
        case (s.seq)
          i2cm_pkg::SEQ_START, i2cm_pkg::SEQ_RESTART: begin
            if (s.sub < 2'd2) begin
              s.sub = s.sub + 1'b1;
            end else begin
              s.sub = '0;
              s.bitn = '0;
              s.ackf = 1'b0;
              if (s.seq == i2cm_pkg::SEQ_START) begin
                s.shreg = s.slave;
                s.seq = i2cm_pkg::SEQ_SLAVE;
              end else begin
                s.shreg = s.slave + 8'd1;
                s.seq = i2cm_pkg::SEQ_SLAVE_RD;
              end
            end
          end
          i2cm_pkg::SEQ_SLAVE, i2cm_pkg::SEQ_REG, i2cm_pkg::SEQ_DATA,
          i2cm_pkg::SEQ_SLAVE_RD, i2cm_pkg::SEQ_READ: begin
            if (s.sub == 2'd1) begin
              if (s.seq == i2cm_pkg::SEQ_READ) begin
                if (s.bitn < 4'd8) s.shreg = {s.shreg[6:0], it.sda_in};
              end else if (s.bitn == 4'd8) begin
                s.ackf = it.sda_in;
              end
            end
            if (s.sub < 2'd2) begin
              s.sub = s.sub + 1'b1;
            end else begin
              s.sub = '0;
              if (s.bitn < 4'd8) begin
                if (s.seq != i2cm_pkg::SEQ_READ) s.shreg = {s.shreg[6:0], 1'b0};
                s.bitn = s.bitn + 1'b1;
              end else begin
                s.bitn = '0;
                // missing acknowledge goes straight to stop
                if (s.seq != i2cm_pkg::SEQ_READ && s.ackf) begin
                  s.seq = i2cm_pkg::SEQ_STOP;
                end else begin
                  case (s.seq)
                    i2cm_pkg::SEQ_SLAVE: begin
                      s.seq = i2cm_pkg::SEQ_REG;
                      s.shreg = s.regb;
                    end
                    i2cm_pkg::SEQ_REG: begin
                      if (s.cmd == i2cm_pkg::CMD_READ) begin
                        s.seq = i2cm_pkg::SEQ_RESTART;
                      end else begin
                        s.seq = i2cm_pkg::SEQ_DATA;
                        s.shreg = s.data;
                      end
                    end
                    i2cm_pkg::SEQ_SLAVE_RD: begin
                      s.seq = i2cm_pkg::SEQ_READ;
                      s.shreg = '0;
                    end
                    default: begin
                      s.err = 1'b0;
                      s.seq = i2cm_pkg::SEQ_STOP;
                    end
                  endcase
                end
              end
            end
          end
          i2cm_pkg::SEQ_STOP: begin
            if (s.sub < 2'd3) begin
              s.sub = s.sub + 1'b1;
            end else begin
              done = 1'b1;
              if (s.cmd == i2cm_pkg::CMD_READ) s.rdata = s.err ? 8'd0 : s.shreg;
              s.seq = i2cm_pkg::SEQ_IDLE;
              s.sub = '0;
            end
          end
          default: begin
            s.seq = i2cm_pkg::SEQ_IDLE;
            s.sub = '0;
          end
        endcase
      end
    end
    r = '0;
    r.scl_out = 1'b1;
    r.sda_out = 1'b1;
    case (s.seq)
      i2cm_pkg::SEQ_START, i2cm_pkg::SEQ_RESTART: begin
        r.scl_out = (s.sub < 2'd2);
        r.sda_out = (s.sub == 2'd0);
      end
      i2cm_pkg::SEQ_SLAVE, i2cm_pkg::SEQ_REG, i2cm_pkg::SEQ_DATA,
      i2cm_pkg::SEQ_SLAVE_RD, i2cm_pkg::SEQ_READ: begin
        r.scl_out = (s.sub == 2'd1);
        r.sda_out = (s.seq == i2cm_pkg::SEQ_READ || s.bitn >= 4'd8) ? 1'b1 : s.shreg[7];
      end
      i2cm_pkg::SEQ_STOP: begin
        r.scl_out = (s.sub >= 2'd2);
        r.sda_out = (s.sub == 2'd0 || s.sub == 2'd3);
      end
      default: begin
      end
    endcase
    r.busy_res = (s.seq != i2cm_pkg::SEQ_IDLE);
    r.done_res = done;
    r.error = s.err;
    r.read_data = s.rdata;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (n_mismatch < 40)
      $display("mismatch %s: got %0h want %0h at transfer %0d", what, got, want, n_results);
    n_mismatch++;
  endtask

  task automatic queue_tick(input i2cm_pkg::item_t it);
    void'(next_bus_levels(seq_ahead, it));
    tick_q.push_back(it);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly whole transactions; acks are usually given, now and then refused
  task automatic add_traffic(input int unsigned n);
    i2cm_pkg::item_t it;
    for (int unsigned k = 0; k < n; k++) begin
      it.cmd = 1'($urandom_range(0, 1));
      it.slave_byte = ($urandom_range(0, 3) == 0) ? 8'hFF : pick_byte();
      it.reg_addr = pick_byte();
      it.write_data = pick_byte();
      it.sda_in = 1'($urandom_range(0, 1));
      if (seq_ahead.seq == i2cm_pkg::SEQ_IDLE) it.start_req = ($urandom_range(0, 3) != 0);
      else if (seq_ahead.seq == i2cm_pkg::SEQ_STOP) it.start_req = 1'($urandom_range(0, 1));
      else it.start_req = ($urandom_range(0, 15) == 0);
      if (seq_ahead.seq inside {i2cm_pkg::SEQ_SLAVE, i2cm_pkg::SEQ_REG,
                                i2cm_pkg::SEQ_DATA, i2cm_pkg::SEQ_SLAVE_RD} &&
          seq_ahead.bitn == 4'd8)
        it.sda_in = ($urandom_range(0, 9) == 0);
      queue_tick(it);
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // driver and result-side stalls
  always @(negedge clk_i) begin
    logic            nv;
    i2cm_pkg::item_t nxt;
    nv = in_valid;
    nxt = cur_tick;
    if (rst_ni) begin
      if (!in_valid || in_taken) begin
        nv = 1'b0;
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 4);
        end else if (tick_q.size() > 0) begin
          nv = 1'b1;
          nxt = tick_q.pop_front();
        end
      end
      if (out_gap > 0) begin
        out_gap = out_gap - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
    in_valid <= nv;
    cur_tick <= nxt;
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    i2cm_pkg::res_t got;
    i2cm_pkg::res_t want;
    if (rst_ni) begin
      if (cfg_we) seq_model.ticks = cfg_wdata;
      if (out_valid_o && out_ready) begin
        got = {scl_out_o, sda_out_o, busy_res_o, done_res_o, error_o, read_data_o};
        if (bus_levels_q.size() == 0) begin
          report_mismatch("result with nothing pending", got.read_data, 8'h00);
        end else begin
          want = bus_levels_q.pop_front();
          if (got.scl_out !== want.scl_out)
            report_mismatch("scl_out", 8'(got.scl_out), 8'(want.scl_out));
          if (got.sda_out !== want.sda_out)
            report_mismatch("sda_out", 8'(got.sda_out), 8'(want.sda_out));
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
          if (got.done_res !== want.done_res)
            report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
          if (got.error !== want.error)
            report_mismatch("error", 8'(got.error), 8'(want.error));
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
        end
        n_results++;
      end
      if (in_valid && in_ready_o) bus_levels_q.push_back(next_bus_levels(seq_model, cur_tick));
      in_taken <= in_valid && in_ready_o;
    end
  end

  initial begin
    int unsigned phase_cfg [N_PHASES];
    int unsigned phase_len [N_PHASES];
    i2cm_pkg::item_t it;
    phase_cfg = '{0, 1, 2, 65535, 1, 3, 0, 1, 1};
    phase_len = '{200, 200, 150, 30, 200, 150, 150, 150, 120};
    seq_model = bus_reset();
    seq_ahead = bus_reset();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed ticks at the reset phase time
    it = '{start_req: 1'b0, cmd: i2cm_pkg::CMD_READ, slave_byte: 8'hFF, reg_addr: 8'hFF,
           write_data: 8'hFF, sda_in: 1'b1};
    queue_tick(it);
    it = '{start_req: 1'b0, cmd: i2cm_pkg::CMD_WRITE, slave_byte: 8'h00, reg_addr: 8'h00,
           write_data: 8'h00, sda_in: 1'b0};
    queue_tick(it);
    // read with slave byte that wraps on plus one
    it = '{start_req: 1'b1, cmd: i2cm_pkg::CMD_READ, slave_byte: 8'hFF, reg_addr: 8'h00,
           write_data: 8'hFF, sda_in: 1'b1};
    queue_tick(it);
    // requests while busy are ignored
    for (int k = 0; k < 18; k++) begin
      it = '{start_req: 1'b1, cmd: k[0] ? i2cm_pkg::CMD_READ : i2cm_pkg::CMD_WRITE,
             slave_byte: k[0] ? 8'h00 : 8'hFF, reg_addr: k[0] ? 8'hFF : 8'h00,
             write_data: k[0] ? 8'h00 : 8'hFF, sda_in: k[1]};
      queue_tick(it);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      while (tick_q.size() != 0 || bus_levels_q.size() != 0 || in_valid)
        @(posedge clk_i);
      repeat (4) @(negedge clk_i);
      cfg_we <= 1'b1;
      cfg_wdata <= i2cm_pkg::CFG_WIDTH'(phase_cfg[p]);
      @(negedge clk_i);
      cfg_we <= 1'b0;
      seq_ahead.ticks = 16'(phase_cfg[p]);
      if (p == N_PHASES - 1) calm = 1'b1;
      add_traffic(phase_len[p]);
    end

    while (tick_q.size() != 0 || bus_levels_q.size() != 0 || in_valid)
      @(posedge clk_i);
    repeat (8) @(negedge clk_i);
    if (n_mismatch == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
